// ===== hw/rtl/lrupr_pkg.sv =====
// Package for the LRU page replacement block: controller states,
// controller-to-datapath command struct and fixed field widths.
// No dependencies.
package lrupr_pkg;

   // Fixed port widths
   localparam int unsigned CFG_W     = 4;
   localparam int unsigned PAGE_ID_W = 8;
   localparam int unsigned FAULT_W   = 16;

   // Reset and saturation values
   localparam logic [CFG_W-1:0]   FRAME_LIMIT_RST = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX       = 16'hFFFF;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lrupr_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the referenced page
      logic lookup;   // compare all frames, register the match vector
      logic update;   // commit the stack, counters and result
   } lrupr_cmd_type;

endpackage

// ===== hw/rtl/lrupr_ctrl.sv =====
// Controller of the LRU page replacement block: sequences lookup and update.
// Depends on lrupr_pkg.
module lrupr_ctrl
   import lrupr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output lrupr_cmd_type cmd
);

   lrupr_state_type state_ff;
   lrupr_state_type state_in;

   // Next state: a new transfer may enter while the previous one commits
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = start ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = start ? ST_LOOKUP : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      busy       = (state_ff == ST_LOOKUP);
      cmd.load   = start && (state_ff != ST_LOOKUP);
      cmd.lookup = (state_ff == ST_LOOKUP);
      cmd.update = (state_ff == ST_UPDATE);
   end

   // Lookup is always followed by an update
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_UPDATE)
      else $error("lookup not followed by update");

   // Every accepted transfer goes to lookup next
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_LOOKUP)
      else $error("accepted transfer did not enter lookup");

   // Nothing is accepted while busy
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load)
      else $error("load issued while busy");

endmodule

// ===== hw/rtl/lrupr_datapath.sv =====
// Datapath of the LRU page replacement block: recency stack registers,
// parallel compare, shift/append update, counters and result registers.
// Depends on lrupr_pkg.
module lrupr_datapath
   import lrupr_pkg::*;
#(
   parameter int unsigned FRAMES    = 8,
   parameter int unsigned PAGE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lrupr_cmd_type        cmd,
   input  logic [PAGE_ID_W-1:0] req_page_id,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output logic                 rsp_valid,
   output logic                 rsp_was_hit,
   output logic                 rsp_evict_valid,
   output logic [PAGE_ID_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]   rsp_fault_total
);

   // Stored page width: only the low bits that fit both the page and the port
   localparam int unsigned PW    = (PAGE_BITS < PAGE_ID_W) ? PAGE_BITS : PAGE_ID_W;
   localparam int unsigned OCC_W = $clog2(FRAMES + 1);
   localparam int unsigned CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;

   logic [PW-1:0]        stack_ff [FRAMES];
   logic [PW-1:0]        page_ff;
   logic [FRAMES-1:0]    match_ff;
   logic [FRAMES-1:0]    match_in;
   logic [OCC_W-1:0]     occ_ff;
   logic [OCC_W-1:0]     occ_in;
   logic [FAULT_W-1:0]   fault_ff;
   logic [FAULT_W-1:0]   fault_in;
   logic [CFG_W-1:0]     frame_limit_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_was_hit_ff;
   logic                 rsp_evict_valid_ff;
   logic [PAGE_ID_W-1:0] rsp_evicted_page_ff;
   logic [FAULT_W-1:0]   rsp_fault_total_ff;

   logic [CW-1:0]        flim_ext;
   logic [CW-1:0]        lim;
   logic                 hit;
   logic                 evict;
   logic [OCC_W-1:0]     wr_pos;
   logic [FRAMES-1:0]    shift_en;
   logic                 shift_run;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= FRAME_LIMIT_RST;
      end else if (csr_wr_en) begin
         frame_limit_ff <= csr_wr_data;
      end
   end

   // Capture the referenced page on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_page_id[PW-1:0];
      end
   end

   // Compare every resident frame against the page
   always_comb begin
      for (int unsigned i = 0; i < FRAMES; i++) begin
         match_in[i] = (OCC_W'(i) < occ_ff) && (stack_ff[i] == page_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         match_ff <= match_in;
      end
   end

   // Effective frame limit: zero acts as one, above FRAMES acts as FRAMES
   always_comb begin
      flim_ext = CW'(frame_limit_ff);
      if (flim_ext == '0) begin
         lim = CW'(1);
      end else if (flim_ext > CW'(FRAMES)) begin
         lim = CW'(FRAMES);
      end else begin
         lim = flim_ext;
      end
   end

   // Decide hit, eviction and where the page lands
   always_comb begin
      hit    = |match_ff;
      evict  = !hit && (occ_ff != '0) && (CW'(occ_ff) >= lim);
      wr_pos = (hit || evict) ? (occ_ff - OCC_W'(1)) : occ_ff;
      // Entries from the hit position (or all, on eviction) up to the
      // write position take their upper neighbor
      shift_run = evict;
      for (int unsigned i = 0; i < FRAMES; i++) begin
         shift_run   = shift_run | match_ff[i];
         shift_en[i] = shift_run && (OCC_W'(i) < wr_pos);
      end
   end

   // Recency stack: shift down, then write the page at the most-recent end
   for (genvar g = 0; g < FRAMES; g++) begin : g_entry
      logic [PW-1:0] upper;
      if (g + 1 < FRAMES) begin : g_mid
         assign upper = stack_ff[g+1];
      end else begin : g_top
         assign upper = stack_ff[g];
      end
      always_ff @(posedge clock) begin
         if (cmd.update) begin
            if (OCC_W'(g) == wr_pos) begin
               stack_ff[g] <= page_ff;
            end else if (shift_en[g]) begin
               stack_ff[g] <= upper;
            end
         end
      end
   end

   // Occupancy and saturating fault count
   always_comb begin
      occ_in   = (hit || evict) ? occ_ff : (occ_ff + OCC_W'(1));
      fault_in = (!hit && (fault_ff != FAULT_MAX)) ? (fault_ff + FAULT_W'(1)) : fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         fault_ff <= '0;
      end else if (cmd.update) begin
         occ_ff   <= occ_in;
         fault_ff <= fault_in;
      end
   end

   // Result registers: one-cycle strobe after the update
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_was_hit_ff      <= hit;
         rsp_evict_valid_ff  <= evict;
         rsp_evicted_page_ff <= evict ? PAGE_ID_W'(stack_ff[0]) : '0;
         rsp_fault_total_ff  <= fault_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_hit      = rsp_was_hit_ff;
   assign rsp_evict_valid  = rsp_evict_valid_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_total  = rsp_fault_total_ff;

   // Resident pages are unique, so at most one frame matches
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $onehot0(match_ff))
      else $error("page resident in more than one frame");

   // Occupancy never exceeds the built frame count
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(FRAMES))
      else $error("occupancy above frame count");

   // A hit leaves occupancy unchanged
   assert property (@(posedge clock) disable iff (reset)
      cmd.update && hit |=> $stable(occ_ff))
      else $error("occupancy changed on a hit");

   // An eviction is never reported together with a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_hit && rsp_evict_valid))
      else $error("hit and eviction reported together");

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// LRU page replacement, top level. The start transfer captures the page, the lookup
// state compares all frames, the update state commits the stack and a result register
// drives the strobe. A new reference may start in the update state of the previous one,
// not in its lookup, as the stack is compared, then shifted; busy is high in lookup only.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Reset clears occupancy, the fault count and sets frame_limit to 8; stack needs none.
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int unsigned FRAMES    = 8,
   parameter int unsigned PAGE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PAGE_ID_W-1:0] req_page_id,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output logic                 rsp_valid,
   output logic                 rsp_was_hit,
   output logic                 rsp_evict_valid,
   output logic [PAGE_ID_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]   rsp_fault_total
);

   lrupr_cmd_type cmd;

   // Sequence lookup and update
   lrupr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold the stack, counters and results
   lrupr_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_page_id      (req_page_id),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_was_hit      (rsp_was_hit),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total)
   );

endmodule
